/* sv/pcdh_pkg.sv */
// ----------------------------------------------------------------------------
// pcdh_pkg
// Shared types and constants for the per-chromosome depth histogram core.
// ----------------------------------------------------------------------------
`default_nettype none

package pcdh_pkg;

  localparam int unsigned NUM_CHROM_DEF  = 32;
  localparam int unsigned DEPTH_BINS_DEF = 256;

  localparam int unsigned CHROM_IN_W = 5;
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned MBIN_W     = 8;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SUM_W      = 48;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SMP_RD,
    ST_SMP_SUM,
    ST_SMP_CNT,
    ST_SMP_BIN,
    ST_QRY_RD,
    ST_QRY_LOAD,
    ST_WALK_RD,
    ST_WALK_ACC,
    ST_OUT
  } pcdh_state_e;

  // operands for the shared saturating adder
  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [CNT_W-1:0] b;
    logic             wide;  // clamp at the sum maximum instead of the counter maximum
  } pcdh_op_t;

endpackage : pcdh_pkg

`default_nettype wire

/* sv/per_chromosome_depth_histogram_core.sv */
// ----------------------------------------------------------------------------
// per_chromosome_depth_histogram_core
// Per-chromosome coverage depth histogram with depth sums, position counts
// and a median bin query.
//
// input channel (in_valid_i / in_stall_o): kind_i selects a depth sample or a
//   query for chromosome chrom_i. a sample updates sum, count and one bin and
//   returns nothing; a query returns one transaction on the output channel.
// output channel (out_valid_o / out_stall_i): chrom_out_o, median_found_o,
//   median_bin_o, positions_o, depth_total_o held in an output register.
// sequencing: one item at a time, set by the sequencer around one shared
//   saturating adder and the registered-read stats and histogram rams.
//   sample: read, add the depth to the sum, write sum and count, write the bin.
//   query: read, load the stats, walk the bins (at most DEPTH_BINS) to the
//   output register; an out-of-range chromosome goes there straight from idle.
// reset: a clearing pass writes zero to every bin and every sum/count entry,
//   NUM_CHROM*DEPTH_BINS bin addresses in turn (8192 at default), in_stall_o high.
// output stall: a finished result waits in the output register; samples go on
//   being accepted, a following query waits in its last step until the
//   register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module per_chromosome_depth_histogram_core
  import pcdh_pkg::*;
#(
  parameter int unsigned NUM_CHROM  = NUM_CHROM_DEF,
  parameter int unsigned DEPTH_BINS = DEPTH_BINS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  kind_i,
  input  wire logic [CHROM_IN_W-1:0] chrom_i,
  input  wire logic [DEPTH_W-1:0]    depth_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [CHROM_IN_W-1:0] chrom_out_o,
  output logic                       median_found_o,
  output logic      [MBIN_W-1:0]     median_bin_o,
  output logic      [CNT_W-1:0]      positions_o,
  output logic      [SUM_W-1:0]      depth_total_o
);

  localparam int unsigned CHROM_W = (NUM_CHROM > 1) ? $clog2(NUM_CHROM) : 1;
  localparam int unsigned BIN_W   = (DEPTH_BINS > 1) ? $clog2(DEPTH_BINS) : 1;
  localparam int unsigned BAW     = CHROM_W + BIN_W;
  localparam int unsigned STAT_W  = SUM_W + CNT_W;

  localparam logic [CHROM_W-1:0] LAST_CHROM = CHROM_W'(NUM_CHROM - 1);
  localparam logic [BIN_W-1:0]   LAST_BIN   = BIN_W'(DEPTH_BINS - 1);

  pcdh_state_e state_q, state_d;

  // item and walk registers
  logic [CHROM_IN_W-1:0] chrom_raw_q;
  logic [CHROM_W-1:0]    chrom_q;
  logic [DEPTH_W-1:0]    depth_q;
  logic [BIN_W-1:0]      idx_q;
  logic [SUM_W-1:0]      acc_q;
  logic [CNT_W-2:0]      half_q;
  logic [CNT_W-1:0]      pos_q;
  logic [SUM_W-1:0]      tot_q;
  logic                  found_q;
  logic [BIN_W-1:0]      mbin_q;
  logic [CHROM_W-1:0]    clr_chrom_q;
  logic [BIN_W-1:0]      clr_bin_q;

  logic                  out_valid_q;
  logic [CHROM_IN_W-1:0] chrom_out_q;
  logic                  median_found_q;
  logic [MBIN_W-1:0]     median_bin_q;
  logic [CNT_W-1:0]      positions_q;
  logic [SUM_W-1:0]      depth_total_q;

  // ram ports
  logic              stats_we;
  logic [CHROM_W-1:0] stats_waddr;
  logic [STAT_W-1:0] stats_wdata;
  logic [STAT_W-1:0] stats_rdata;
  logic              bins_we;
  logic [BAW-1:0]    bins_waddr;
  logic [CNT_W-1:0]  bins_wdata;
  logic [CNT_W-1:0]  bins_rdata;

  pcdh_op_t         op;
  logic [SUM_W-1:0] res;

  logic in_accept;
  logic chrom_ok;
  logic [BIN_W-1:0] smp_bin;
  logic ld_stats;
  logic walk_hit;
  logic walk_next;
  logic acc_ld;
  logic out_load;
  logic clr_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign chrom_ok   = (32'(chrom_i) < NUM_CHROM);
  assign smp_bin    = (32'(depth_i) >= DEPTH_BINS - 1) ? LAST_BIN : BIN_W'(depth_i);
  assign clr_last   = (clr_chrom_q == LAST_CHROM) && (clr_bin_q == LAST_BIN);

  pcdh_sat_add u_add (
    .op_i  (op),
    .res_o (res)
  );

  pcdh_ram #(
    .WIDTH (STAT_W),
    .DEPTH (NUM_CHROM)
  ) u_stats_ram (
    .clk_i   (clk_i),
    .we_i    (stats_we),
    .waddr_i (stats_waddr),
    .wdata_i (stats_wdata),
    .raddr_i (chrom_q),
    .rdata_o (stats_rdata)
  );

  pcdh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (2 ** BAW)
  ) u_bins_ram (
    .clk_i   (clk_i),
    .we_i    (bins_we),
    .waddr_i (bins_waddr),
    .wdata_i (bins_wdata),
    .raddr_i ({chrom_q, idx_q}),
    .rdata_o (bins_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    stats_we    = 1'b0;
    stats_waddr = chrom_q;
    stats_wdata = {acc_q, res[CNT_W-1:0]};
    bins_we     = 1'b0;
    bins_waddr  = {chrom_q, idx_q};
    bins_wdata  = res[CNT_W-1:0];
    op.a        = acc_q;
    op.b        = bins_rdata;
    op.wide     = 1'b1;
    ld_stats    = 1'b0;
    walk_hit    = 1'b0;
    walk_next   = 1'b0;
    acc_ld      = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        stats_we    = (clr_bin_q == '0);
        stats_waddr = clr_chrom_q;
        stats_wdata = '0;
        bins_we     = 1'b1;
        bins_waddr  = {clr_chrom_q, clr_bin_q};
        bins_wdata  = '0;
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (!chrom_ok) begin
            state_d = (kind_i == KIND_QUERY) ? ST_OUT : ST_IDLE;
          end else if (kind_i == KIND_QUERY) begin
            state_d = ST_QRY_RD;
          end else begin
            state_d = ST_SMP_RD;
          end
        end
      end
      ST_SMP_RD: begin
        state_d = ST_SMP_SUM;
      end
      ST_SMP_SUM: begin
        op.a    = stats_rdata[STAT_W-1:CNT_W];
        op.b    = CNT_W'(depth_q);
        acc_ld  = 1'b1;
        state_d = ST_SMP_CNT;
      end
      ST_SMP_CNT: begin
        op.a     = SUM_W'(stats_rdata[CNT_W-1:0]);
        op.b     = CNT_W'(1);
        op.wide  = 1'b0;
        stats_we = 1'b1;
        state_d  = ST_SMP_BIN;
      end
      ST_SMP_BIN: begin
        op.a    = SUM_W'(bins_rdata);
        op.b    = CNT_W'(1);
        op.wide = 1'b0;
        bins_we = 1'b1;
        state_d = ST_IDLE;
      end
      ST_QRY_RD: begin
        state_d = ST_QRY_LOAD;
      end
      ST_QRY_LOAD: begin
        ld_stats = 1'b1;
        state_d  = ST_WALK_ACC;
      end
      ST_WALK_RD: begin
        state_d = ST_WALK_ACC;
      end
      ST_WALK_ACC: begin
        // cumulative count reaches half while the count before this bin is below it
        if ((res >= SUM_W'(half_q)) && (SUM_W'(half_q) > acc_q)) begin
          walk_hit = 1'b1;
          state_d  = ST_OUT;
        end else if (idx_q == LAST_BIN) begin
          state_d = ST_OUT;
        end else begin
          walk_next = 1'b1;
          acc_ld    = 1'b1;
          state_d   = ST_WALK_RD;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // clearing pass counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_chrom_q <= '0;
      clr_bin_q   <= '0;
    end else if (state_q == ST_CLEAR) begin
      if (clr_bin_q == LAST_BIN) begin
        clr_bin_q   <= '0;
        clr_chrom_q <= clr_chrom_q + CHROM_W'(1);
      end else begin
        clr_bin_q <= clr_bin_q + BIN_W'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      chrom_raw_q <= chrom_i;
      chrom_q     <= CHROM_W'(chrom_i);
      depth_q     <= depth_i;
      idx_q       <= (kind_i == KIND_QUERY) ? '0 : smp_bin;
      found_q     <= 1'b0;
      mbin_q      <= '0;
      pos_q       <= '0;
      tot_q       <= '0;
    end
    if (ld_stats) begin
      pos_q  <= stats_rdata[CNT_W-1:0];
      tot_q  <= stats_rdata[STAT_W-1:CNT_W];
      half_q <= stats_rdata[CNT_W-1:1];
      acc_q  <= '0;
    end
    if (acc_ld) begin
      acc_q <= res;
    end
    if (walk_next) begin
      idx_q <= idx_q + BIN_W'(1);
    end
    if (walk_hit) begin
      found_q <= 1'b1;
      mbin_q  <= idx_q;
    end
    if (out_load) begin
      chrom_out_q    <= chrom_raw_q;
      median_found_q <= found_q;
      median_bin_q   <= MBIN_W'(mbin_q);
      positions_q    <= pos_q;
      depth_total_q  <= tot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chrom_out_o    = chrom_out_q;
  assign median_found_o = median_found_q;
  assign median_bin_o   = median_bin_q;
  assign positions_o    = positions_q;
  assign depth_total_o  = depth_total_q;

endmodule : per_chromosome_depth_histogram_core

`default_nettype wire

/* sv/pcdh_ram.sv */
// ----------------------------------------------------------------------------
// pcdh_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdh_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule : pcdh_ram

`default_nettype wire

/* sv/pcdh_sat_add.sv */
// ----------------------------------------------------------------------------
// pcdh_sat_add
// Shared saturating adder: clamps at the 48-bit sum maximum or the 32-bit
// counter maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdh_sat_add
  import pcdh_pkg::*;
(
  input  wire pcdh_op_t         op_i,
  output logic      [SUM_W-1:0] res_o
);

  logic [SUM_W:0] sum;
  logic [SUM_W:0] lim;

  always_comb begin
    sum   = {1'b0, op_i.a} + (SUM_W+1)'(op_i.b);
    lim   = op_i.wide ? {1'b0, SUM_MAX} : (SUM_W+1)'(CNT_MAX);
    res_o = (sum > lim) ? lim[SUM_W-1:0] : sum[SUM_W-1:0];
  end

endmodule : pcdh_sat_add

`default_nettype wire

/* dv/pcdh_checker.sv */
// ----------------------------------------------------------------------------
// pcdh_checker
// Watches both channels of the depth histogram core, keeps its own copy of
// the per-chromosome bins, sums and position counts, works out the report of
// every accepted query and compares it field by field with the core's output.
// ----------------------------------------------------------------------------
module pcdh_checker
  import pcdh_pkg::*;
#(
  parameter int unsigned NUM_CHROM  = NUM_CHROM_DEF,
  parameter int unsigned DEPTH_BINS = DEPTH_BINS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  kind_i,
  input  logic [CHROM_IN_W-1:0] chrom_i,
  input  logic [DEPTH_W-1:0]    depth_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [CHROM_IN_W-1:0] chrom_out_i,
  input  logic                  median_found_i,
  input  logic [MBIN_W-1:0]     median_bin_i,
  input  logic [CNT_W-1:0]      positions_i,
  input  logic [SUM_W-1:0]      depth_total_i,
  output int                    mismatches_o,
  output int                    reports_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHROM_IN_W-1:0] chrom;
    logic                  found;
    logic [MBIN_W-1:0]     bin;
    logic [CNT_W-1:0]      positions;
    logic [SUM_W-1:0]      total;
  } depth_report_t;

  logic [CNT_W-1:0] bin_count [NUM_CHROM][DEPTH_BINS];
  logic [SUM_W-1:0] depth_sum [NUM_CHROM];
  logic [CNT_W-1:0] pos_count [NUM_CHROM];

  depth_report_t report_q [$];
  int            mismatches = 0;

  assign mismatches_o      = mismatches;
  assign reports_pending_o = report_q.size();

  function automatic logic [CNT_W-1:0] bump_count(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  task automatic record_sample(logic [CHROM_IN_W-1:0] c, logic [DEPTH_W-1:0] d);
    int unsigned    bin;
    logic [SUM_W:0] grown;
    if (c >= NUM_CHROM) return;
    // deep samples all land in the last bin
    bin = (d >= DEPTH_BINS - 1) ? DEPTH_BINS - 1 : d;
    grown = {1'b0, depth_sum[c]} + d;
    depth_sum[c] = (grown > {1'b0, SUM_MAX}) ? SUM_MAX : grown[SUM_W-1:0];
    pos_count[c] = bump_count(pos_count[c]);
    bin_count[c][bin] = bump_count(bin_count[c][bin]);
  endtask

  function automatic depth_report_t predict_median(logic [CHROM_IN_W-1:0] c);
    depth_report_t    r;
    longint unsigned  half;
    longint unsigned  below;
    longint unsigned  upto;
    r = '0;
    r.chrom = c;
    below = 0;
    upto = 0;
    if (c < NUM_CHROM) begin
      r.positions = pos_count[c];
      r.total = depth_sum[c];
      half = pos_count[c] >> 1;
      for (int i = 0; i < DEPTH_BINS; i++) begin
        upto += bin_count[c][i];
        if (upto >= half && half > below) begin
          r.found = 1'b1;
          r.bin = i[MBIN_W-1:0];
          break;
        end
        below = upto;
      end
    end
    return r;
  endfunction

  // append a predicted report at the tail of the pending list
  task automatic queue_report(depth_report_t r);
    report_q.insert(report_q.size(), r);
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_report();
    depth_report_t want;
    if (report_q.size() == 0) begin
      $error("report for chrom %0d with no query outstanding", chrom_out_i);
      mismatches++;
      return;
    end
    want = report_q.pop_front();
    check_field("chrom_out", want.chrom, chrom_out_i);
    check_field("median_found", want.found, median_found_i);
    check_field("median_bin", want.bin, median_bin_i);
    check_field("positions", want.positions, positions_i);
    check_field("depth_total", want.total, depth_total_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHROM; c++) begin
        depth_sum[c] = '0;
        pos_count[c] = '0;
        for (int b = 0; b < DEPTH_BINS; b++) bin_count[c][b] = '0;
      end
      report_q.delete();
    end else begin
      // retire the finished report before queuing a new query
      if (out_valid_i && !out_stall_i) check_report();
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == KIND_SAMPLE) record_sample(chrom_i, depth_i);
        else queue_report(predict_median(chrom_i));
      end
    end
  end

endmodule : pcdh_checker

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Top of the depth histogram core testbench: drives depth samples and median
// queries under several idle and stall patterns, runs a watchdog and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;
  import pcdh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1330;
  localparam int PHASE_ITEMS  = 160;
  localparam int QUIET_LIMIT  = 40000;  // covers the clearing pass after reset
  localparam int DRAIN_CYCLES = 600;    // longer than a full bin walk

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  kind_i;
  logic [CHROM_IN_W-1:0] chrom_i;
  logic [DEPTH_W-1:0]    depth_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [CHROM_IN_W-1:0] chrom_out_o;
  logic                  median_found_o;
  logic [MBIN_W-1:0]     median_bin_o;
  logic [CNT_W-1:0]      positions_o;
  logic [SUM_W-1:0]      depth_total_o;

  int mismatches;
  int reports_pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  per_chromosome_depth_histogram_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .chrom_i        (chrom_i),
    .depth_i        (depth_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .chrom_out_o    (chrom_out_o),
    .median_found_o (median_found_o),
    .median_bin_o   (median_bin_o),
    .positions_o    (positions_o),
    .depth_total_o  (depth_total_o)
  );

  pcdh_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .kind_i            (kind_i),
    .chrom_i           (chrom_i),
    .depth_i           (depth_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .chrom_out_i       (chrom_out_o),
    .median_found_i    (median_found_o),
    .median_bin_i      (median_bin_o),
    .positions_i       (positions_o),
    .depth_total_i     (depth_total_o),
    .mismatches_o      (mismatches),
    .reports_pending_o (reports_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver back-pressure
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("per_chromosome_depth_histogram_core verification failed");
    $finish;
  end

  task automatic set_traffic(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 57; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 57; end
      default: begin send_idle_pct = 33; stall_pct = 33; end
    endcase
  endtask

  task automatic push_item(logic k, logic [CHROM_IN_W-1:0] c, logic [DEPTH_W-1:0] d);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    kind_i = k;
    chrom_i = c;
    depth_i = d;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [DEPTH_W-1:0] pick_depth();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return DEPTH_W'($urandom_range(12));
    if (roll < 70) return DEPTH_W'($urandom_range(300));
    if (roll < 85) return DEPTH_W'($urandom_range(260, 250));
    return DEPTH_W'($urandom());
  endfunction

  initial begin
    logic [CHROM_IN_W-1:0] c;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = KIND_SAMPLE;
    chrom_i = '0;
    depth_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty and single-position chromosomes, clamping, last-bin median
    set_traffic(0);
    push_item(KIND_QUERY, 5'd0, 16'd0);
    push_item(KIND_SAMPLE, 5'd0, 16'd0);
    push_item(KIND_QUERY, 5'd0, 16'd0);
    push_item(KIND_SAMPLE, 5'd0, 16'hFFFF);
    push_item(KIND_QUERY, 5'd0, 16'h0000);
    push_item(KIND_SAMPLE, 5'd31, 16'd254);
    push_item(KIND_SAMPLE, 5'd31, 16'd255);
    push_item(KIND_SAMPLE, 5'd31, 16'd256);
    push_item(KIND_QUERY, 5'd31, 16'hFFFF);
    push_item(KIND_SAMPLE, 5'd31, 16'hAAAA);
    push_item(KIND_SAMPLE, 5'd31, 16'h5555);
    push_item(KIND_QUERY, 5'd31, 16'h1234);
    push_item(KIND_SAMPLE, 5'd5, 16'd1);
    push_item(KIND_SAMPLE, 5'd5, 16'd1);
    push_item(KIND_QUERY, 5'd5, 16'd0);
    push_item(KIND_SAMPLE, 5'd5, 16'd3);
    push_item(KIND_SAMPLE, 5'd5, 16'd3);
    push_item(KIND_SAMPLE, 5'd5, 16'd0);
    push_item(KIND_QUERY, 5'd5, 16'd0);
    push_item(KIND_QUERY, 5'd17, 16'd7);

    // random: most samples go to a few chromosomes so medians move around
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) set_traffic((n / PHASE_ITEMS) % 4);
      c = ($urandom_range(99) < 70) ? CHROM_IN_W'($urandom_range(3))
                                    : CHROM_IN_W'($urandom_range(31));
      if ($urandom_range(99) < 8) push_item(KIND_QUERY, c, DEPTH_W'($urandom()));
      else push_item(KIND_SAMPLE, c, pick_depth());
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (reports_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) $display("per_chromosome_depth_histogram_core verification clean");
    else $display("per_chromosome_depth_histogram_core verification failed");
    $finish;
  end

endmodule : tb
